/* rtl/arp_resolver_cache_top_macros.svh */
// Assertion macros for the ARP resolver cache checker.
// Included by the checker file only.
`ifndef ARP_RESOLVER_CACHE_TOP_MACROS_SVH
`define ARP_RESOLVER_CACHE_TOP_MACROS_SVH
`define ARC_ASSERT_IMPL(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error("assertion failed");
`define ARC_ASSERT(lbl, prop) \
    `ARC_ASSERT_IMPL(lbl, clk, rst_n, prop)
`endif

/* rtl/arc_pkg.sv */
`timescale 1ns / 1ps
// Package for the ARP resolver cache: request/result structs, codes, defaults.
// No dependencies.
package arc_pkg;
    localparam int CacheDepthDef   = 16;
    localparam int RequestDepthDef = 8;
    localparam int PendingDepthDef = 16;

    localparam logic [15:0] HoldoffReset  = 16'd5000;
    localparam logic [31:0] LifetimeReset = 32'd30000;
    localparam logic [47:0] MacBcast      = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_ARP  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_SEND    = 3'd0,
        ACT_REQUEST = 3'd1,
        ACT_REPLY   = 3'd2,
        ACT_QUEUED  = 3'd3,
        ACT_DROPPED = 3'd4,
        ACT_BADOP   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REG_OWN_MAC  = 2'd0,
        REG_OWN_IP   = 2'd1,
        REG_HOLDOFF  = 2'd2,
        REG_LIFETIME = 2'd3
    } reg_idx_t;

    localparam logic [15:0] OpRequest = 16'd1;
    localparam logic [15:0] OpReply   = 16'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] next_hop_ip;
        logic [15:0] datagram_tag;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [15:0] arp_opcode;
        logic [15:0] elapsed_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] dst_mac;
        logic [31:0] dst_ip;
        logic [15:0] out_tag;
        logic        last;
    } res_t;
endpackage

/* rtl/arp_resolver_cache_top.sv */
`timescale 1ns / 1ps
// ARP resolver: IP-to-MAC cache, request holdoff table, pending tag queue.
// Depends on arc_pkg.
//
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_stall | req_t
// res     | out | res_valid/res_stall | res_t
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Every table is walked one entry a cycle through a single compare/age unit.
// Results leave through one output register; a stall there freezes the pending-queue
// walk. Reset clears valid bits, time and own MAC/IP, and loads the holdoff and
// lifetime defaults; no clearing pass.
module arp_resolver_cache_top
    import arc_pkg::*;
#(
    parameter int CACHE_DEPTH   = CacheDepthDef,
    parameter int REQUEST_DEPTH = RequestDepthDef,
    parameter int PENDING_DEPTH = PendingDepthDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int RW = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CFIND  = 11'b00000000010,
        S_RFIND  = 11'b00000000100,
        S_RSLOT  = 11'b00000001000,
        S_SENDQ  = 11'b00000010000,
        S_SENDR  = 11'b00000100000,
        S_CSLOT  = 11'b00001000000,
        S_LEARN  = 11'b00010000000,
        S_PSCAN  = 11'b00100000000,
        S_FINAL  = 11'b01000000000,
        S_TICK   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] holdoff_reg;
    logic [31:0] lifetime_reg;
    logic [31:0] now_reg;

    logic [CACHE_DEPTH-1:0]   cv_reg;
    logic [31:0] c_ip   [CACHE_DEPTH];
    logic [47:0] c_mac  [CACHE_DEPTH];
    logic [31:0] c_time [CACHE_DEPTH];
    logic [REQUEST_DEPTH-1:0] rv_reg;
    logic [31:0] r_ip   [REQUEST_DEPTH];
    logic [31:0] r_time [REQUEST_DEPTH];
    logic [PENDING_DEPTH-1:0] pv_reg;
    logic [31:0] p_ip   [PENDING_DEPTH];
    logic [15:0] p_tag  [PENDING_DEPTH];

    req_t        in_reg;
    logic [8:0]  idx_reg;
    logic [PW-1:0] wr_reg;
    logic [8:0]  best_reg;
    logic [31:0] best_age_reg;
    logic        out_v_reg;
    res_t        out_reg;
    logic        hit_reg;
    logic        held_reg;
    logic        have_reg;
    logic [15:0] held_tag_reg;

    logic busy;
    assign busy = (state_reg != S_IDLE);
    assign req_stall = busy || out_v_reg;
    assign cfg_ready = !busy && !out_v_reg;
    assign res_valid = out_v_reg;
    assign res = out_reg;

    logic out_free;
    assign out_free = !out_v_reg || !res_stall;

    // shared compare/age unit
    logic [31:0] cmp_ip, cmp_time, age;
    logic        cmp_v, eq;
    logic [CW-1:0] ci;
    logic [RW-1:0] ri;
    logic [PW-1:0] pi;
    assign ci = idx_reg[CW-1:0];
    assign ri = idx_reg[RW-1:0];
    assign pi = idx_reg[PW-1:0];
    always_comb
    begin
        cmp_ip = '0; cmp_time = '0; cmp_v = 1'b0;
        if (state_reg == S_RFIND || state_reg == S_RSLOT)
        begin
            cmp_ip = r_ip[ri]; cmp_time = r_time[ri]; cmp_v = rv_reg[ri];
        end
        else if (state_reg == S_PSCAN)
        begin
            cmp_ip = p_ip[pi]; cmp_v = pv_reg[pi];
        end
        else
        begin
            cmp_ip = c_ip[ci]; cmp_time = c_time[ci]; cmp_v = cv_reg[ci];
        end
    end
    logic [31:0] key_ip;
    assign key_ip = (in_reg.kind == KIND_SEND) ? in_reg.next_hop_ip : in_reg.sender_ip;
    assign eq  = cmp_v && (cmp_ip == key_ip);
    assign age = now_reg - cmp_time;

    logic [8:0] idx_inc;
    assign idx_inc = idx_reg + 9'd1;

    // output register loads this cycle
    logic out_load;
    always_comb
    begin
        out_load = 1'b0;
        if (out_free)
        begin
            unique case (state_reg)
                S_SENDQ, S_SENDR: out_load = 1'b1;
                S_PSCAN:          out_load = eq && have_reg;
                S_FINAL:          out_load = have_reg || (in_reg.arp_opcode != OpReply);
                default:          out_load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            own_mac_reg  <= '0;
            own_ip_reg   <= '0;
            holdoff_reg  <= HoldoffReset;
            lifetime_reg <= LifetimeReset;
            now_reg      <= '0;
            cv_reg       <= '0;
            rv_reg       <= '0;
            pv_reg       <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_v_reg <= 1'b1;
            else if (!res_stall)
                out_v_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_OWN_MAC:  own_mac_reg  <= cfg_data[47:0];
                    REG_OWN_IP:   own_ip_reg   <= cfg_data[31:0];
                    REG_HOLDOFF:  holdoff_reg  <= cfg_data[15:0];
                    REG_LIFETIME: lifetime_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && !req_stall)
                    begin
                        unique case (kind_t'(req.kind))
                            KIND_SEND: state_reg <= S_CFIND;
                            KIND_ARP:  state_reg <= (req.target_ip == own_ip_reg) ?
                                                    S_CFIND : S_IDLE;
                            KIND_TICK: state_reg <= S_TICK;
                            default:   state_reg <= S_IDLE;
                        endcase
                        if (req.kind == KIND_TICK)
                            now_reg <= now_reg + {16'd0, req.elapsed_ms};
                    end
                end
                S_CFIND:
                begin
                    if (eq)
                        best_reg <= idx_reg;
                    if (idx_reg == 9'(CACHE_DEPTH - 1) || eq)
                    begin
                        idx_reg <= '0;
                        if (in_reg.kind == KIND_SEND)
                            state_reg <= eq ? S_SENDQ : S_RFIND;
                        else
                            state_reg <= eq ? S_LEARN : S_CSLOT;
                        hit_reg <= eq;
                    end
                    else
                        idx_reg <= idx_inc;
                end
                S_CSLOT:
                begin
                    if (!cmp_v || idx_reg == '0 || age > best_age_reg)
                    begin
                        best_reg <= idx_reg; best_age_reg <= age;
                    end
                    if (!cmp_v || idx_reg == 9'(CACHE_DEPTH - 1))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_LEARN;
                    end
                    else
                        idx_reg <= idx_inc;
                end
                S_LEARN:
                begin
                    // write cache, then look for holdoff entry to clear
                    cv_reg[best_reg[CW-1:0]]  <= 1'b1;
                    c_ip[best_reg[CW-1:0]]    <= in_reg.sender_ip;
                    c_mac[best_reg[CW-1:0]]   <= in_reg.sender_mac;
                    c_time[best_reg[CW-1:0]]  <= now_reg;
                    idx_reg   <= '0;
                    state_reg <= S_RFIND;
                end
                S_RFIND:
                begin
                    if (eq)
                    begin
                        best_reg <= idx_reg;
                        best_age_reg <= age;
                    end
                    if (idx_reg == 9'(REQUEST_DEPTH - 1) || eq)
                    begin
                        idx_reg <= '0;
                        if (in_reg.kind == KIND_ARP)
                        begin
                            if (eq)
                                rv_reg[ri] <= 1'b0;
                            wr_reg <= '0;
                            state_reg <= S_PSCAN;
                        end
                        else if (eq)
                        begin
                            held_reg  <= (age <= {16'd0, holdoff_reg});
                            state_reg <= S_SENDQ;
                        end
                        else
                            state_reg <= S_RSLOT;
                    end
                    else
                        idx_reg <= idx_inc;
                end
                S_RSLOT:
                begin
                    if (!cmp_v || idx_reg == '0 || age > best_age_reg)
                    begin
                        best_reg <= idx_reg; best_age_reg <= age;
                    end
                    if (!cmp_v || idx_reg == 9'(REQUEST_DEPTH - 1))
                        state_reg <= S_SENDQ;
                    else
                        idx_reg <= idx_inc;
                end
                S_SENDQ:
                begin
                    if (out_free)
                    begin
                        out_reg.dst_ip  <= in_reg.next_hop_ip;
                        out_reg.out_tag <= in_reg.datagram_tag;
                        if (hit_reg)
                        begin
                            out_reg.action  <= ACT_SEND;
                            out_reg.dst_mac <= c_mac[best_reg[CW-1:0]];
                            out_reg.last    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_reg.dst_mac <= '0;
                            out_reg.last    <= held_reg;
                            if (!pv_reg[PENDING_DEPTH-1])
                            begin
                                out_reg.action <= ACT_QUEUED;
                                for (int k = 0; k < PENDING_DEPTH; k++)
                                begin
                                    if (!pv_reg[k] && (k == 0 || pv_reg[k == 0 ? 0 : k-1]))
                                    begin
                                        pv_reg[k] <= 1'b1;
                                        p_ip[k]   <= in_reg.next_hop_ip;
                                        p_tag[k]  <= in_reg.datagram_tag;
                                    end
                                end
                            end
                            else
                                out_reg.action <= ACT_DROPPED;
                            state_reg <= held_reg ? S_IDLE : S_SENDR;
                        end
                    end
                end
                S_SENDR:
                begin
                    if (out_free)
                    begin
                        rv_reg[best_reg[RW-1:0]] <= 1'b1;
                        r_ip[best_reg[RW-1:0]]   <= in_reg.next_hop_ip;
                        r_time[best_reg[RW-1:0]] <= now_reg;
                        out_reg.action  <= ACT_REQUEST;
                        out_reg.dst_mac <= MacBcast;
                        out_reg.dst_ip  <= in_reg.next_hop_ip;
                        out_reg.out_tag <= '0;
                        out_reg.last    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_PSCAN:
                begin
                    // a released tag is held back one match so its last bit is known
                    if (!cmp_v)
                    begin
                        for (int k = 0; k < PENDING_DEPTH; k++)
                            if (k >= int'(wr_reg))
                                pv_reg[k] <= 1'b0;
                        state_reg <= S_FINAL;
                    end
                    else if (eq)
                    begin
                        if (!have_reg || out_free)
                        begin
                            if (have_reg)
                            begin
                                out_reg.action  <= ACT_SEND;
                                out_reg.dst_mac <= in_reg.sender_mac;
                                out_reg.dst_ip  <= in_reg.sender_ip;
                                out_reg.out_tag <= held_tag_reg;
                                out_reg.last    <= 1'b0;
                            end
                            have_reg     <= 1'b1;
                            held_tag_reg <= p_tag[pi];
                            if (idx_reg == 9'(PENDING_DEPTH - 1))
                            begin
                                for (int k = 0; k < PENDING_DEPTH; k++)
                                    if (k >= int'(wr_reg))
                                        pv_reg[k] <= 1'b0;
                                state_reg <= S_FINAL;
                            end
                            else
                                idx_reg <= idx_inc;
                        end
                    end
                    else
                    begin
                        p_ip[wr_reg]  <= p_ip[pi];
                        p_tag[wr_reg] <= p_tag[pi];
                        if (idx_reg == 9'(PENDING_DEPTH - 1))
                        begin
                            for (int k = 0; k < PENDING_DEPTH; k++)
                                if (k > int'(wr_reg))
                                    pv_reg[k] <= 1'b0;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            wr_reg  <= wr_reg + PW'(1);
                            idx_reg <= idx_inc;
                        end
                    end
                end
                S_FINAL:
                begin
                    if (have_reg)
                    begin
                        if (out_free)
                        begin
                            out_reg.action  <= ACT_SEND;
                            out_reg.dst_mac <= in_reg.sender_mac;
                            out_reg.dst_ip  <= in_reg.sender_ip;
                            out_reg.out_tag <= held_tag_reg;
                            out_reg.last    <= (in_reg.arp_opcode == OpReply);
                            have_reg <= 1'b0;
                            if (in_reg.arp_opcode == OpReply)
                                state_reg <= S_IDLE;
                        end
                    end
                    else if (in_reg.arp_opcode == OpReply)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        out_reg.out_tag <= '0;
                        out_reg.last    <= 1'b1;
                        if (in_reg.arp_opcode == OpRequest)
                        begin
                            out_reg.action  <= ACT_REPLY;
                            out_reg.dst_mac <= in_reg.sender_mac;
                            out_reg.dst_ip  <= in_reg.sender_ip;
                        end
                        else
                        begin
                            out_reg.action  <= ACT_BADOP;
                            out_reg.dst_mac <= '0;
                            out_reg.dst_ip  <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_TICK:
                begin
                    if (cv_reg[ci] && age > lifetime_reg)
                        cv_reg[ci] <= 1'b0;
                    if (idx_reg == 9'(CACHE_DEPTH - 1))
                        state_reg <= S_IDLE;
                    else
                        idx_reg <= idx_inc;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_IDLE && req_valid && !req_stall)
            begin
                in_reg    <= req;
                idx_reg   <= '0;
                hit_reg   <= 1'b0;
                held_reg  <= 1'b0;
                have_reg  <= 1'b0;
                best_age_reg <= '0;
            end
        end
    end
endmodule

/* rtl/arp_resolver_cache_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the ARP resolver cache, bound to the top level.
// Depends on arc_pkg and the macros header.
`include "arp_resolver_cache_top_macros.svh"
module arp_resolver_cache_chk
    import arc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res,
    input logic cfg_ready
);
    `ARC_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res))
    `ARC_ASSERT(a_action_ok, res_valid |-> res.action <= ACT_BADOP)
    `ARC_ASSERT(a_acc_empty, req_valid && !req_stall |-> !res_valid)
    `ARC_ASSERT(a_cfg_busy, res_valid |-> !cfg_ready)
endmodule

bind arp_resolver_cache_top arp_resolver_cache_chk u_chk (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
    .res_valid(res_valid), .res_stall(res_stall), .res(res), .cfg_ready(cfg_ready)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for arp_resolver_cache_top: directed and random requests,
// results predicted by a behavioural model of the cache and compared in order.
// Depends on arc_pkg and the RTL top.
module tb;
    import arc_pkg::*;

    localparam int NCACHE = 16;
    localparam int NREQ   = 8;
    localparam int NPEND  = 16;
    localparam int LIMIT  = 2000000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        res_valid;
    logic        res_stall;
    res_t        res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    arp_resolver_cache_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [47:0] m_mac;
    logic [31:0] m_ip;
    logic [15:0] m_holdoff;
    logic [31:0] m_lifetime;
    logic [31:0] m_now;
    logic        c_v [NCACHE];
    logic [31:0] c_ip [NCACHE];
    logic [47:0] c_mac [NCACHE];
    logic [31:0] c_t [NCACHE];
    logic        r_v [NREQ];
    logic [31:0] r_ip [NREQ];
    logic [31:0] r_t [NREQ];
    logic        p_v [NPEND];
    logic [31:0] p_ip [NPEND];
    logic [15:0] p_tag [NPEND];

    res_t expected_q [$];
    res_t item_res [$];
    int   fails;
    int   reported;
    longint cycles;
    int   send_idle;
    int   recv_idle;
    bit   hold_recv;

    // known IP pool keeps hits, releases and holdoffs frequent
    logic [31:0] ip_pool [8];
    logic [47:0] mac_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic res_t mk(action_t a, logic [47:0] mac, logic [31:0] ip,
                                logic [15:0] tag);
        res_t r;
        r.action  = a;
        r.dst_mac = mac;
        r.dst_ip  = ip;
        r.out_tag = tag;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic predict_send(input logic [31:0] ip, input logic [15:0] tag);
        int c;
        int p;
        int r;
        int best;
        logic [31:0] age;
        logic [31:0] best_age;
        c = -1;
        p = NPEND;
        r = -1;
        for (int i = NCACHE - 1; i >= 0; i--)
            if (c_v[i] && c_ip[i] == ip)
                c = i;
        if (c >= 0)
        begin
            item_res.push_back(mk(ACT_SEND, c_mac[c], ip, tag));
            return;
        end
        for (int i = NPEND - 1; i >= 0; i--)
            if (!p_v[i])
                p = i;
        if (p < NPEND)
        begin
            p_v[p] = 1'b1;
            p_ip[p] = ip;
            p_tag[p] = tag;
            item_res.push_back(mk(ACT_QUEUED, '0, ip, tag));
        end
        else
            item_res.push_back(mk(ACT_DROPPED, '0, ip, tag));
        for (int i = NREQ - 1; i >= 0; i--)
            if (r_v[i] && r_ip[i] == ip)
                r = i;
        if (r >= 0 && (m_now - r_t[r]) <= {16'd0, m_holdoff})
            return;
        if (r < 0)
        begin
            best = -1;
            best_age = '0;
            for (int i = 0; i < NREQ; i++)
            begin
                if (best < 0 || r_v[best])
                begin
                    if (!r_v[i])
                        best = i;
                    else
                    begin
                        age = m_now - r_t[i];
                        if (best < 0 || age > best_age)
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                end
            end
            r = best;
        end
        r_v[r] = 1'b1;
        r_ip[r] = ip;
        r_t[r] = m_now;
        item_res.push_back(mk(ACT_REQUEST, MacBcast, ip, '0));
    endtask

    task automatic predict_arp(input req_t it);
        int c;
        int w;
        int best;
        logic [31:0] age;
        logic [31:0] best_age;
        if (it.target_ip != m_ip)
            return;
        c = -1;
        for (int i = NCACHE - 1; i >= 0; i--)
            if (c_v[i] && c_ip[i] == it.sender_ip)
                c = i;
        if (c < 0)
        begin
            best = -1;
            best_age = '0;
            for (int i = 0; i < NCACHE; i++)
            begin
                if (best < 0 || c_v[best])
                begin
                    if (!c_v[i])
                        best = i;
                    else
                    begin
                        age = m_now - c_t[i];
                        if (best < 0 || age > best_age)
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                end
            end
            c = best;
        end
        c_v[c] = 1'b1;
        c_ip[c] = it.sender_ip;
        c_mac[c] = it.sender_mac;
        c_t[c] = m_now;
        for (int i = 0; i < NREQ; i++)
            if (r_v[i] && r_ip[i] == it.sender_ip)
            begin
                r_v[i] = 1'b0;
                break;
            end
        w = 0;
        for (int i = 0; i < NPEND; i++)
        begin
            if (p_v[i])
            begin
                if (p_ip[i] == it.sender_ip)
                    item_res.push_back(mk(ACT_SEND, it.sender_mac, it.sender_ip, p_tag[i]));
                else
                begin
                    p_ip[w] = p_ip[i];
                    p_tag[w] = p_tag[i];
                    p_v[w] = 1'b1;
                    w++;
                end
            end
        end
        for (int i = w; i < NPEND; i++)
            p_v[i] = 1'b0;
        if (it.arp_opcode == OpRequest)
            item_res.push_back(mk(ACT_REPLY, it.sender_mac, it.sender_ip, '0));
        else if (it.arp_opcode != OpReply)
            item_res.push_back(mk(ACT_BADOP, '0, '0, '0));
    endtask

    task automatic predict_request(input req_t it);
        item_res = {};
        case (kind_t'(it.kind))
            KIND_SEND: predict_send(it.next_hop_ip, it.datagram_tag);
            KIND_ARP:  predict_arp(it);
            KIND_TICK:
            begin
                m_now = m_now + {16'd0, it.elapsed_ms};
                for (int i = 0; i < NCACHE; i++)
                    if (c_v[i] && (m_now - c_t[i]) > m_lifetime)
                        c_v[i] = 1'b0;
            end
            default: ;
        endcase
        if (item_res.size() > 0)
            item_res[item_res.size() - 1].last = 1'b1;
        foreach (item_res[i])
            expected_q.push_back(item_res[i]);
    endtask

    // valid stays up after an accept; the next task lowers it or offers a new request
    task automatic send_request(input req_t it);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        predict_request(it);
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        req_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_OWN_MAC:  m_mac = val[47:0];
            REG_OWN_IP:   m_ip = val[31:0];
            REG_HOLDOFF:  m_holdoff = val[15:0];
            REG_LIFETIME: m_lifetime = val[31:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic req_t blank(kind_t k);
        req_t it;
        it = '0;
        it.kind = k;
        return it;
    endfunction

    task automatic do_send(input logic [31:0] ip, input logic [15:0] tag);
        req_t it;
        it = blank(KIND_SEND);
        it.next_hop_ip = ip;
        it.datagram_tag = tag;
        send_request(it);
    endtask

    task automatic do_arp(input logic [31:0] sip, input logic [47:0] smac,
                          input logic [31:0] tip, input logic [15:0] op);
        req_t it;
        it = blank(KIND_ARP);
        it.sender_ip = sip;
        it.sender_mac = smac;
        it.target_ip = tip;
        it.arp_opcode = op;
        send_request(it);
    endtask

    task automatic do_tick(input logic [15:0] ms);
        req_t it;
        it = blank(KIND_TICK);
        it.elapsed_ms = ms;
        send_request(it);
    endtask

    function automatic req_t random_request(int noise);
        req_t it;
        int k;
        it = '0;
        it.kind = 2'($urandom_range(3));
        it.next_hop_ip = $urandom();
        it.datagram_tag = 16'($urandom());
        it.sender_ip = $urandom();
        it.sender_mac = 48'({$urandom(), $urandom()});
        it.target_ip = $urandom();
        it.arp_opcode = 16'($urandom());
        it.elapsed_ms = 16'($urandom());
        if ($urandom_range(99) >= noise)
        begin
            k = $urandom_range(9);
            it.kind = (k < 5) ? KIND_SEND : (k < 8) ? KIND_ARP : KIND_TICK;
            it.next_hop_ip = ip_pool[$urandom_range(7)];
            k = $urandom_range(7);
            it.sender_ip = ip_pool[k];
            it.sender_mac = $urandom_range(3) == 0 ? mac_pool[k] : it.sender_mac;
            if ($urandom_range(9) != 0)
                it.target_ip = m_ip;
            if ($urandom_range(9) < 8)
                it.arp_opcode = 16'($urandom_range(1, 2));
            if ($urandom_range(3) != 0)
                it.elapsed_ms = 16'($urandom_range(4000));
        end
        return it;
    endfunction

    task automatic test_directed;
        write_reg(REG_OWN_MAC, 64'h0000_0211_2233_4455);
        write_reg(REG_OWN_IP, 64'h0000_0000_0A00_0001);
        do_send(32'hFFFF_FFFF, 16'hFFFF);
        do_send(32'hFFFF_FFFF, 16'h0000);
        do_send(32'h0000_0000, 16'h1234);
        do_arp(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0A00_0001, OpReply);
        do_send(32'hFFFF_FFFF, 16'h5555);
        do_arp(32'h0000_0000, 48'h0, 32'h0A00_0001, OpRequest);
        do_arp(32'h0A00_0002, 48'h0A0B_0C0D_0E0F, 32'h0A00_0001, 16'hFFFF);
        do_arp(32'h0A00_0003, 48'h1, 32'h0A00_0009, OpRequest);
        do_tick(16'hFFFF);
        do_tick(16'h0);
        for (int i = 0; i < 17; i++)
            do_send(32'h0B00_0000 + i[31:0], i[15:0]);
        do_arp(32'h0B00_0003, 48'hA5A5_5A5A_A5A5, 32'h0A00_0001, OpRequest);
        for (int i = 0; i < 18; i++)
            do_arp(32'h0C00_0000 + i[31:0], {16'h0, i[31:0]}, 32'h0A00_0001, OpReply);
        do_send(32'h0D00_0000, 16'h0);
        do_send(32'h0D00_0000, 16'h1);
        drain();
    endtask

    task automatic test_random(input int n, input int noise);
        for (int i = 0; i < n; i++)
            send_request(random_request(noise));
    endtask

    task automatic test_backpressure;
        hold_recv = 1'b1;
        for (int i = 0; i < 12; i++)
            do_send(32'h0E00_0000 + i[31:0], i[15:0]);
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(REG_HOLDOFF, 64'h0);
        write_reg(REG_LIFETIME, 64'h0);
        write_reg(REG_OWN_IP, 64'hFFFF_FFFF);
        write_reg(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
        test_random(40, 20);
        drain();
        write_reg(REG_HOLDOFF, 64'hFFFF);
        write_reg(REG_LIFETIME, 64'hFFFF_FFFF);
        write_reg(REG_OWN_IP, 64'h0);
        write_reg(REG_OWN_MAC, 64'h0);
        test_random(40, 20);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_OWN_MAC;
        cfg_data = '0;
        fails = 0;
        reported = 0;
        cycles = 0;
        hold_recv = 1'b0;
        send_idle = 15;
        recv_idle = 79;
        m_mac = '0;
        m_ip = '0;
        m_holdoff = HoldoffReset;
        m_lifetime = LifetimeReset;
        m_now = '0;
        for (int i = 0; i < NCACHE; i++) c_v[i] = 1'b0;
        for (int i = 0; i < NREQ; i++) r_v[i] = 1'b0;
        for (int i = 0; i < NPEND; i++) p_v[i] = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            ip_pool[i] = $urandom();
            mac_pool[i] = 48'({$urandom(), $urandom()});
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(70, 10);
        drain();
        send_idle = 79;
        recv_idle = 15;
        test_backpressure();
        write_reg(REG_HOLDOFF, 64'd300);
        write_reg(REG_LIFETIME, 64'd6000);
        write_reg(REG_OWN_IP, {32'h0, ip_pool[0]});
        test_random(50, 10);
        drain();
        send_idle = 0;
        recv_idle = 0;
        test_config_extremes();
        drain();
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_recv)
        begin
            res_stall <= 1'b1;
            repeat (400) @(posedge clk);
            hold_recv <= 1'b0;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_q.size() == 0)
            begin
                fails++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result %p", res);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.action !== want.action || res.dst_mac !== want.dst_mac
                    || res.dst_ip !== want.dst_ip || res.out_tag !== want.out_tag
                    || res.last !== want.last)
                begin
                    fails++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("mismatch: expected %p got %p", want, res);
                    end
                end
            end
        end
    end
endmodule

/* arp_resolver_cache_top.f */
+incdir+rtl
rtl/arc_pkg.sv
rtl/arp_resolver_cache_top.sv
rtl/arp_resolver_cache_chk.sv
verif/tb.sv
